FILE: rtl/lsoc_pkg.sv
// Package for the lidar sweep obstacle cost core.
// Holds widths, register codes, reset values and the controller/datapath structs.
// No dependencies.
`default_nettype none

package lsoc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COST_W    = 40;
  localparam int SCAN_W    = 11;
  localparam int HALF_W    = SCAN_W - 1;
  localparam int QUOT_W    = 25;                 // 2^24 / 1 needs 25 bits
  localparam int STEP_W    = $clog2(QUOT_W);
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;

  localparam int MAX_SCAN_POINTS_DEF = 1024;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SAFE_DISTANCE = 2'd0,
    REG_INFLUENCE     = 2'd1,
    REG_SCAN_SIZE     = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  localparam logic [SAMPLE_W-1:0] SAFE_DISTANCE_RST = 16'd256;
  localparam logic [SAMPLE_W-1:0] INFLUENCE_RST     = 16'd512;
  localparam logic [SCAN_W-1:0]   SCAN_SIZE_RST     = 11'd360;

  typedef struct packed {
    logic [SAMPLE_W-1:0] safe_distance;
    logic [SAMPLE_W-1:0] influence_threshold;
    logic [SCAN_W-1:0]   scan_size;
  } cfg_t;

  typedef struct packed {
    logic load;      // capture accepted sample, start divider
    logic div_step;  // one quotient bit
    logic acc;       // add reciprocal to selected side
    logic emit;      // copy sums to output, clear sweep state
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic is_last;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/lsoc_in_if.sv
// Input channel interface of the lidar sweep obstacle cost core.
// Depends on lsoc_pkg for field widths.
`default_nettype none

interface lsoc_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsoc_pkg::SAMPLE_W-1:0] range_sample;
  logic                         sample_invalid;
  logic                         sweep_end;

  modport source (output valid, range_sample, sample_invalid, sweep_end, input ready);
  modport sink   (input valid, range_sample, sample_invalid, sweep_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/lsoc_out_if.sv
// Result channel interface of the lidar sweep obstacle cost core.
// Depends on lsoc_pkg for field widths.
`default_nettype none

interface lsoc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsoc_pkg::COST_W-1:0] left_cost;
  logic [lsoc_pkg::COST_W-1:0] right_cost;
  logic                        object_near;

  modport source (output valid, left_cost, right_cost, object_near, input ready);
  modport sink   (input valid, left_cost, right_cost, object_near, output ready);
endinterface

`default_nettype wire

FILE: rtl/lsoc_regs.sv
// APB-style configuration registers of the lidar sweep obstacle cost core.
// Depends on lsoc_pkg.
`default_nettype none

module lsoc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [lsoc_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [lsoc_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic      [lsoc_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready,
  output lsoc_pkg::cfg_t                     cfg
);

  lsoc_pkg::cfg_t     cfg_r;
  lsoc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx        = lsoc_pkg::reg_idx_t'(cfg_paddr[lsoc_pkg::ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safe_distance       <= lsoc_pkg::SAFE_DISTANCE_RST;
      cfg_r.influence_threshold <= lsoc_pkg::INFLUENCE_RST;
      cfg_r.scan_size           <= lsoc_pkg::SCAN_SIZE_RST;
    end else if (wr_en) begin
      unique case (idx)
        lsoc_pkg::REG_SAFE_DISTANCE:
          cfg_r.safe_distance <= cfg_pwdata[lsoc_pkg::SAMPLE_W-1:0];
        lsoc_pkg::REG_INFLUENCE:
          cfg_r.influence_threshold <= cfg_pwdata[lsoc_pkg::SAMPLE_W-1:0];
        lsoc_pkg::REG_SCAN_SIZE:
          cfg_r.scan_size <= cfg_pwdata[lsoc_pkg::SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lsoc_pkg::REG_SAFE_DISTANCE:
        cfg_prdata = lsoc_pkg::DATA_W'(cfg_r.safe_distance);
      lsoc_pkg::REG_INFLUENCE:
        cfg_prdata = lsoc_pkg::DATA_W'(cfg_r.influence_threshold);
      lsoc_pkg::REG_SCAN_SIZE:
        cfg_prdata = lsoc_pkg::DATA_W'(cfg_r.scan_size);
      default:
        cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lsoc_ctrl.sv
// Controller state machine of the lidar sweep obstacle cost core.
// Sequences accept, reciprocal division, accumulate and emit. Depends on lsoc_pkg.
`default_nettype none

module lsoc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire lsoc_pkg::dp_status_t status,
  output lsoc_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ACC,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!status.need_div) begin
          state_nxt = status.is_last ? S_EMIT : S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
          if (status.div_done) state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = status.is_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lsoc_dp.sv
// Datapath of the lidar sweep obstacle cost core: sample capture, radix-2
// reciprocal divider, saturating side sums and output register. Depends on lsoc_pkg.
`default_nettype none

module lsoc_dp #(
  parameter int MAX_SCAN_POINTS = lsoc_pkg::MAX_SCAN_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lsoc_pkg::cfg_t                cfg,
  input  wire lsoc_pkg::ctrl_cmd_t           cmd,
  output lsoc_pkg::dp_status_t               status,
  input  wire logic [lsoc_pkg::SAMPLE_W-1:0] range_sample,
  input  wire logic                          sample_invalid,
  input  wire logic                          sweep_end,
  output logic      [lsoc_pkg::COST_W-1:0]   left_cost,
  output logic      [lsoc_pkg::COST_W-1:0]   right_cost,
  output logic                               object_near
);

  localparam int IDX_W = $clog2(MAX_SCAN_POINTS);
  localparam int CMP_W = (IDX_W > lsoc_pkg::HALF_W) ? IDX_W : lsoc_pkg::HALF_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SCAN_POINTS - 1);
  localparam logic [lsoc_pkg::STEP_W-1:0] STEP_TOP = lsoc_pkg::STEP_W'(lsoc_pkg::QUOT_W - 1);

  // sweep state
  logic [IDX_W-1:0]              idx_r;
  logic [lsoc_pkg::COST_W-1:0]   left_sum_r, right_sum_r;
  logic                          near_r;
  // per-sample state
  logic [lsoc_pkg::SAMPLE_W-1:0] den_r;
  logic                          need_div_r, last_r, to_left_r;
  // divider
  logic [lsoc_pkg::SAMPLE_W-1:0] rem_r;
  logic [lsoc_pkg::QUOT_W-1:0]   quot_r;
  logic [lsoc_pkg::STEP_W-1:0]   step_r;
  // output register
  logic [lsoc_pkg::COST_W-1:0]   left_out_r, right_out_r;
  logic                          near_out_r;

  logic [lsoc_pkg::HALF_W-1:0]   half;
  logic                          below_half;
  logic [lsoc_pkg::SAMPLE_W:0]   trial;
  logic [lsoc_pkg::SAMPLE_W:0]   trial_diff;
  logic                          fits;
  logic [lsoc_pkg::COST_W-1:0]   acc_base;
  logic [lsoc_pkg::COST_W:0]     acc_sum;
  logic [lsoc_pkg::COST_W-1:0]   acc_sat;

  assign half       = cfg.scan_size[lsoc_pkg::SCAN_W-1:1];
  assign below_half = CMP_W'(idx_r) < CMP_W'(half);

  // dividend is 2^24: its only set bit enters on the first step
  assign trial      = {rem_r, step_r == STEP_TOP};
  assign trial_diff = trial - {1'b0, den_r};
  assign fits       = trial >= {1'b0, den_r};

  assign acc_base = to_left_r ? left_sum_r : right_sum_r;
  assign acc_sum  = {1'b0, acc_base} + (lsoc_pkg::COST_W + 1)'(quot_r);
  assign acc_sat  = acc_sum[lsoc_pkg::COST_W] ? '1 : acc_sum[lsoc_pkg::COST_W-1:0];

  assign status.need_div = need_div_r;
  assign status.is_last  = last_r;
  assign status.div_done = (step_r == '0);

  assign left_cost   = left_out_r;
  assign right_cost  = right_out_r;
  assign object_near = near_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      left_sum_r  <= '0;
      right_sum_r <= '0;
      near_r      <= 1'b0;
      need_div_r  <= 1'b0;
      last_r      <= 1'b0;
    end else if (cmd.load) begin
      need_div_r <= !sample_invalid && (range_sample < cfg.influence_threshold);
      last_r     <= sweep_end;
      if (!sample_invalid && (range_sample < cfg.safe_distance)) near_r <= 1'b1;
      if (idx_r != IDX_LAST) idx_r <= idx_r + IDX_W'(1);
    end else if (cmd.acc) begin
      if (to_left_r) left_sum_r <= acc_sat;
      else           right_sum_r <= acc_sat;
    end else if (cmd.emit) begin
      idx_r       <= '0;
      left_sum_r  <= '0;
      right_sum_r <= '0;
      near_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r     <= (range_sample == '0) ? lsoc_pkg::SAMPLE_W'(1) : range_sample;
      to_left_r <= !below_half;
      rem_r     <= '0;
      quot_r    <= '0;
      step_r    <= STEP_TOP;
    end else if (cmd.div_step) begin
      rem_r  <= fits ? trial_diff[lsoc_pkg::SAMPLE_W-1:0] : trial[lsoc_pkg::SAMPLE_W-1:0];
      quot_r <= {quot_r[lsoc_pkg::QUOT_W-2:0], fits};
      step_r <= step_r - lsoc_pkg::STEP_W'(1);
    end
    if (cmd.emit) begin
      left_out_r  <= left_sum_r;
      right_out_r <= right_sum_r;
      near_out_r  <= near_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lidar_sweep_obstacle_cost_core.sv
// Top level of the lidar sweep obstacle cost core.
// Depends on lsoc_pkg, lsoc_in_if, lsoc_out_if, lsoc_regs, lsoc_ctrl, lsoc_dp.
//
//   channel  | direction | handshake          | payload
//   in_ch    | in        | valid/ready        | range_sample, sample_invalid, sweep_end
//   out_ch   | out       | valid/ready        | left_cost, right_cost, object_near
//   cfg_*    | in        | APB, pready high   | safe_distance, influence_threshold, scan_size
//
// A sample that adds to a cost passes through accept, one divider step per quotient
// bit of the shared radix-2 reciprocal unit and one accumulate; any other sample only
// passes accept and the divide check. A sweep end adds an emit step to load the outputs.
// Synchronous active-low reset clears the sums, index, flag and output valid.
// A stalled result holds the core in its emit step; samples wait on in_ch.ready.
`default_nettype none

module lidar_sweep_obstacle_cost_core #(
  parameter int MAX_SCAN_POINTS = lsoc_pkg::MAX_SCAN_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lsoc_in_if.sink                          in_ch,
  lsoc_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [lsoc_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [lsoc_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [lsoc_pkg::DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  lsoc_pkg::cfg_t       cfg;
  lsoc_pkg::ctrl_cmd_t  cmd;
  lsoc_pkg::dp_status_t status;

  lsoc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lsoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lsoc_dp #(
    .MAX_SCAN_POINTS (MAX_SCAN_POINTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .range_sample   (in_ch.range_sample),
    .sample_invalid (in_ch.sample_invalid),
    .sweep_end      (in_ch.sweep_end),
    .left_cost      (out_ch.left_cost),
    .right_cost     (out_ch.right_cost),
    .object_near    (out_ch.object_near)
  );

endmodule

`default_nettype wire

FILE: rtl/lsoc_checker.sv
// Port-level checker for the lidar sweep obstacle cost core, with its bind.
// Depends on lsoc_pkg and lidar_sweep_obstacle_cost_core.
`default_nettype none

module lsoc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lsoc_pkg::COST_W-1:0] left_cost,
  input wire logic [lsoc_pkg::COST_W-1:0] right_cost,
  input wire logic                        object_near
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one sample in flight: an accepted transaction drops ready
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after accepting a transaction");

  // a result never appears the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result raised too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(left_cost)
      && $stable(right_cost) && $stable(object_near)))
    else $error("stalled result changed");

endmodule

bind lidar_sweep_obstacle_cost_core lsoc_checker u_lsoc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_cost   (out_ch.left_cost),
  .right_cost  (out_ch.right_cost),
  .object_near (out_ch.object_near)
);

`default_nettype wire
